// ===== rtl/core/sha1_pkg.sv =====
package sha1_pkg;

   localparam int WordWidth  = 32;
   localparam int NumWords   = 5;
   localparam int Rounds     = 80;
   localparam int RoundBits  = $clog2(Rounds);
   localparam int BlockBytes = 64;
   localparam int FillBits   = $clog2(BlockBytes);
   localparam int BlockBits  = BlockBytes * 8;
   localparam int SchedWords = BlockBits / WordWidth;
   localparam int LenStart   = BlockBytes - 8;
   localparam int CountBits  = 64;

   typedef logic [WordWidth-1:0] sha1_word_type;
   typedef logic [7:0]           sha1_byte_type;

   typedef struct packed {
      sha1_word_type a;
      sha1_word_type b;
      sha1_word_type c;
      sha1_word_type d;
      sha1_word_type e;
   } sha1_work_type;

   localparam sha1_word_type InitWords [NumWords] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   localparam sha1_byte_type PadMark = 8'h80;

endpackage

// ===== rtl/core/sha1_req_if.sv =====
interface sha1_req_if;
   logic                   valid;
   logic                   ready;
   sha1_pkg::sha1_byte_type data_byte;
   logic                   byte_present;
   logic                   last_of_message;

   modport source (output valid, data_byte, byte_present, last_of_message, input ready);
   modport sink (input valid, data_byte, byte_present, last_of_message, output ready);
endinterface

// ===== rtl/core/sha1_rsp_if.sv =====
interface sha1_rsp_if;
   logic                   valid;
   logic                   ready;
   sha1_pkg::sha1_word_type digest_word0;
   sha1_pkg::sha1_word_type digest_word1;
   sha1_pkg::sha1_word_type digest_word2;
   sha1_pkg::sha1_word_type digest_word3;
   sha1_pkg::sha1_word_type digest_word4;

   modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                   digest_word4, input ready);
   modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                 digest_word4, output ready);
endinterface

// ===== rtl/core/sha1_round.sv =====
module sha1_round (
   input  sha1_pkg::sha1_work_type                work_i,
   input  sha1_pkg::sha1_word_type                sched_i,
   input  logic [sha1_pkg::RoundBits-1:0]         round_i,
   output sha1_pkg::sha1_work_type                work_o
);
   import sha1_pkg::*;

   localparam logic [RoundBits-1:0] PhaseOne   = RoundBits'(20);
   localparam logic [RoundBits-1:0] PhaseTwo   = RoundBits'(40);
   localparam logic [RoundBits-1:0] PhaseThree = RoundBits'(60);

   sha1_word_type mix;
   sha1_word_type round_k;
   sha1_word_type sum;

   always_comb begin
      if (round_i < PhaseOne) begin
         mix     = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
         round_k = 32'h5A82_7999;
      end else if (round_i < PhaseTwo) begin
         mix     = work_i.b ^ work_i.c ^ work_i.d;
         round_k = 32'h6ED9_EBA1;
      end else if (round_i < PhaseThree) begin
         mix     = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
         round_k = 32'h8F1B_BCDC;
      end else begin
         mix     = work_i.b ^ work_i.c ^ work_i.d;
         round_k = 32'hCA62_C1D6;
      end
      sum = {work_i.a[26:0], work_i.a[31:27]} + mix + work_i.e + round_k + sched_i;
      work_o.a = sum;
      work_o.b = work_i.a;
      work_o.c = {work_i.b[1:0], work_i.b[31:2]};
      work_o.d = work_i.c;
      work_o.e = work_i.d;
   end

endmodule

// ===== rtl/core/sha1_hash_engine.sv =====
// Channel   Direction  Handshake      Payload
// req_bus   in         valid / ready  data_byte[7:0], byte_present, last_of_message
// rsp_bus   out        valid / ready  digest_word0..digest_word4 (32 bits each)
//
// A request that neither completes a 64-byte block nor ends the message leaves the engine collecting.
// A request that completes a block starts 80 rounds through the single round unit, then a
// fold of the result into the chaining words.
// On a last request the padding bytes (0x80, zeros, 64-bit length) are pushed one per
// cycle into the block buffer, pausing while a full block is compressed; up to 72 bytes
// (at most 64 when the padding fits the current block) and one or two compressions
// precede loading the digest register once it is free.
// Synchronous reset; no clearing pass. The digest register lets the next message start
// while a digest waits; a second digest waits in the final state until the first is taken.
module sha1_hash_engine (
   input logic        clock,
   input logic        reset,
   sha1_req_if.sink   req_bus,
   sha1_rsp_if.source rsp_bus
);
   import sha1_pkg::*;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_DONE
   } state_type;

   localparam logic [FillBits-1:0]  FillLast  = FillBits'(BlockBytes - 1);
   localparam logic [FillBits-1:0]  FillLen   = FillBits'(LenStart);
   localparam logic [RoundBits-1:0] RoundLast = RoundBits'(Rounds - 1);

   state_type                      state_ff, state_in;
   logic [FillBits-1:0]            fill_ff, fill_in;
   logic [CountBits-1:0]           count_ff, count_in;
   sha1_word_type                  chain_ff [NumWords];
   sha1_word_type                  chain_in [NumWords];
   sha1_work_type                  work_ff, work_in;
   logic [0:SchedWords-1][WordWidth-1:0] sched_ff, sched_in;
   logic [RoundBits-1:0]           round_ff, round_in;
   logic                           pad_ff, pad_in;     // message end seen
   logic                           mark_ff, mark_in;   // 0x80 already pushed
   logic                           len_ff, len_in;     // length bytes under way
   logic                           rsp_valid_ff, rsp_valid_in;
   sha1_word_type                  rsp_word_ff [NumWords];
   sha1_word_type                  rsp_word_in [NumWords];

   sha1_work_type                  round_out;
   logic                           req_fire;
   logic                           push;
   sha1_byte_type                  push_byte;
   sha1_byte_type                  pad_byte;
   logic                           len_phase;
   logic [BlockBits-1:0]           sched_flat;
   sha1_word_type                  sched_new;

   sha1_round u_round (
      .work_i  (work_ff),
      .sched_i (sched_ff[0]),
      .round_i (round_ff),
      .work_o  (round_out)
   );

   assign req_bus.ready = (state_ff == ST_COLLECT);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.digest_word0 = rsp_word_ff[0];
   assign rsp_bus.digest_word1 = rsp_word_ff[1];
   assign rsp_bus.digest_word2 = rsp_word_ff[2];
   assign rsp_bus.digest_word3 = rsp_word_ff[3];
   assign rsp_bus.digest_word4 = rsp_word_ff[4];

   // Length goes in once the buffer reaches byte 56 after the mark; earlier
   // positions, and the tail of a spilled block, take zeros.
   assign len_phase  = mark_ff && (len_ff || (fill_ff == FillLen));
   assign sched_flat = sched_ff;
   assign sched_new  = sched_ff[2] ^ sched_ff[8] ^ sched_ff[13] ^ sched_ff[0];

   always_comb begin
      if (!mark_ff) begin
         pad_byte = PadMark;
      end else if (len_phase) begin
         pad_byte = count_ff[{~fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      sched_in     = sched_ff;
      round_in     = round_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      push         = 1'b0;
      push_byte    = '0;

      // drop the digest once taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_COLLECT: begin
            if (req_fire) begin
               if (req_bus.byte_present) begin
                  push      = 1'b1;
                  push_byte = req_bus.data_byte;
                  count_in  = count_ff + CountBits'(8);
               end
               if (req_bus.last_of_message) begin
                  pad_in = 1'b1;
               end
               if (req_bus.byte_present && (fill_ff == FillLast)) begin
                  state_in = ST_ROUND;
                  round_in = '0;
                  work_in  = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3], chain_ff[4]};
               end else if (req_bus.last_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            // advance one round and slide the schedule window by one word
            work_in  = round_out;
            sched_in = {sched_flat[BlockBits-WordWidth-1:0], sched_new[30:0], sched_new[31]};
            round_in = round_ff + RoundBits'(1);
            if (round_ff == RoundLast) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            if (len_ff) begin
               state_in = ST_DONE;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_COLLECT;
            end
         end
         ST_PAD: begin
            push      = 1'b1;
            push_byte = pad_byte;
            mark_in   = 1'b1;
            if (len_phase) begin
               len_in = 1'b1;
            end
            if (fill_ff == FillLast) begin
               state_in = ST_ROUND;
               round_in = '0;
               work_in  = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3], chain_ff[4]};
            end
         end
         ST_DONE: begin
            // hold until the digest register is free, then restart the message
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_word_in  = chain_ff;
               rsp_valid_in = 1'b1;
               chain_in     = InitWords;
               count_in     = '0;
               fill_in      = '0;
               pad_in       = 1'b0;
               mark_in      = 1'b0;
               len_in       = 1'b0;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      // shift one byte into the block buffer; the fill count wraps at a full block
      if (push) begin
         sched_in = {sched_flat[BlockBits-9:0], push_byte};
         fill_in  = fill_ff + FillBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      sched_ff    <= sched_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_COLLECT;
         fill_ff      <= '0;
         count_ff     <= '0;
         chain_ff     <= InitWords;
         round_ff     <= '0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         len_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         round_ff     <= round_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/sha1_checker.sv =====
module sha1_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_last,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input sha1_pkg::sha1_word_type rsp_word0,
   input sha1_pkg::sha1_word_type rsp_word4
);

   // a pending digest stays up until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("digest dropped before it was taken");

   // a stalled digest holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word0) && $stable(rsp_word4))
      else $error("digest changed while stalled");

   // a message end moves the engine into padding or a compression, so the next request must wait
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken right after a message end");

   // a new digest comes only out of the busy finishing phase
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("digest appeared while collecting bytes");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_last  (req_bus.last_of_message),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_word0 (rsp_bus.digest_word0),
   .rsp_word4 (rsp_bus.digest_word4)
);

// ===== sim/sha1_hash_engine_test.sv =====
module sha1_hash_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sha1_pkg::*;

   // Give up well past the slowest legal run: every block runs 80 rounds and a fold, every
   // message end up to 72 pad pushes plus two compressions, and both sides stall.
   localparam int CycleLimit   = 3_000_000;
   localparam int DrainCycles  = 400;
   localparam int RandomItems  = 1800;

   localparam sha1_word_type RoundConst [4] = '{
      32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
   };

   typedef struct packed {
      sha1_byte_type data_byte;
      logic          byte_present;
      logic          last_of_message;
   } hash_request_type;

   // Word i of the digest sits at index i.
   typedef logic [NumWords-1:0][WordWidth-1:0] digest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1_req_if req_bus ();
   sha1_rsp_if rsp_bus ();

   sha1_hash_engine u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: chaining words, message bit count, block buffer.
   // ------------------------------------------------------------------
   sha1_word_type           hash_words [NumWords];
   logic [CountBits-1:0]    msg_bits;
   sha1_byte_type           msg_block [BlockBytes];
   int                      block_fill;

   digest_type       digest_queue [$];
   hash_request_type pending_requests [$];

   int  error_count     = 0;
   int  digests_checked = 0;
   int  accepted_count  = 0;
   int  total_requests  = 0;
   int  counted_items   = 0;
   int  planned_digests = 0;
   int  cycle_count     = 0;
   logic req_taken      = 1'b0;

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic restart_message();
      for (int i = 0; i < NumWords; i++) hash_words[i] = InitWords[i];
      msg_bits   = '0;
      block_fill = 0;
   endtask

   // Run the 80 rounds over msg_block and fold the result into hash_words.
   task automatic compress_block();
      sha1_word_type sched [Rounds];
      sha1_word_type a, b, c, d, e, fn, tmp, mix;
      for (int t = 0; t < SchedWords; t++)
         sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
      for (int t = SchedWords; t < Rounds; t++) begin
         mix      = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
         sched[t] = {mix[30:0], mix[31]};
      end
      a = hash_words[0];
      b = hash_words[1];
      c = hash_words[2];
      d = hash_words[3];
      e = hash_words[4];
      for (int t = 0; t < Rounds; t++) begin
         if (t < 20) begin
            fn = (b & c) | (~b & d);
         end else if (t < 40 || t >= 60) begin
            fn = b ^ c ^ d;
         end else begin
            fn = (b & c) | (b & d) | (c & d);
         end
         tmp = {a[26:0], a[31:27]} + fn + e + RoundConst[t/20] + sched[t];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = tmp;
      end
      hash_words[0] += a;
      hash_words[1] += b;
      hash_words[2] += c;
      hash_words[3] += d;
      hash_words[4] += e;
   endtask

   // Absorb one accepted request; on a message end, pad, finish, queue the digest.
   task automatic absorb_request(input hash_request_type req);
      digest_type dg;
      int         pos;
      if (req.byte_present) begin
         msg_block[block_fill] = req.data_byte;
         block_fill++;
         msg_bits += 8;
         if (block_fill == BlockBytes) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (req.last_of_message) begin
         pos = block_fill;
         msg_block[pos] = PadMark;
         pos++;
         // Padding overflow: no room left for the length, spill into a second block.
         if (pos > LenStart) begin
            while (pos < BlockBytes) begin
               msg_block[pos] = 8'h00;
               pos++;
            end
            compress_block();
            pos = 0;
         end
         while (pos < LenStart) begin
            msg_block[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) msg_block[LenStart+i] = msg_bits[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < NumWords; i++) dg[i] = hash_words[i];
         digest_queue = {digest_queue, dg};
         restart_message();
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic queue_request(input sha1_byte_type b, input logic present, input logic last);
      hash_request_type r;
      r.data_byte       = b;
      r.byte_present    = present;
      r.last_of_message = last;
      pending_requests = {pending_requests, r};
      if (present || last) counted_items++;
      if (last) planned_digests++;
   endtask

   // Queue a message of random bytes; sprinkle idle requests when noisy, and end it
   // either on the final byte or with a byte-less end request.
   task automatic queue_message(input int len, input bit noisy);
      bit end_on_byte;
      end_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(15) == 0)
            queue_request(sha1_byte_type'($urandom), 1'b0, 1'b0);
         queue_request(sha1_byte_type'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte) queue_request(sha1_byte_type'($urandom), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      case ($urandom_range(4))
         0: return $urandom_range(0, 8);
         1: return $urandom_range(53, 58);
         2: return $urandom_range(61, 66);
         3: return $urandom_range(116, 130);
         default: return $urandom_range(0, 140);
      endcase
   endfunction

   // Pacing phase: first third receiver-heavy stalls, second sender-heavy gaps, last none.
   function automatic int pacing_phase();
      if (total_requests == 0) return 0;
      return (accepted_count * 3) / total_requests;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: change inputs on the falling edge, hold until taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      int               gap_pct;
      hash_request_type r;
      gap_pct = (pacing_phase() == 0) ? 20 : (pacing_phase() == 1) ? 48 : 0;
      if (reset) begin
         req_bus.valid           <= 1'b0;
         req_bus.data_byte       <= '0;
         req_bus.byte_present    <= 1'b0;
         req_bus.last_of_message <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
            r = pending_requests.pop_front();
            req_bus.data_byte       <= r.data_byte;
            req_bus.byte_present    <= r.byte_present;
            req_bus.last_of_message <= r.last_of_message;
            req_bus.valid           <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Digest receiver: stall at random per phase.
   always @(negedge clock) begin
      int stall_pct;
      stall_pct = (pacing_phase() == 0) ? 48 : (pacing_phase() == 1) ? 20 : 0;
      rsp_bus.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      hash_request_type r;
      digest_type       got, want;
      req_taken <= req_bus.valid && req_bus.ready && !reset;
      if (!reset && req_bus.valid && req_bus.ready) begin
         r.data_byte       = req_bus.data_byte;
         r.byte_present    = req_bus.byte_present;
         r.last_of_message = req_bus.last_of_message;
         absorb_request(r);
         accepted_count++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.digest_word4, rsp_bus.digest_word3, rsp_bus.digest_word2,
                rsp_bus.digest_word1, rsp_bus.digest_word0};
         if (digest_queue.size() == 0) begin
            report_error($sformatf("digest %h with no message end pending", got));
         end else begin
            want = digest_queue.pop_front();
            for (int i = 0; i < NumWords; i++)
               if (got[i] !== want[i])
                  report_error($sformatf("digest %0d word %0d: got %h want %h",
                                         digests_checked, i, got[i], want[i]));
            digests_checked++;
         end
      end
   end

   // Hard stop on a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d digests outstanding",
                  cycle_count, digest_queue.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      restart_message();

      // Directed: empty message, idles, "abc" ending on a byte, extreme bytes
      // ended by a byte-less end request, a lone 0x80 byte ending its message, an empty message.
      queue_request(8'h00, 1'b0, 1'b1);
      queue_request(8'hFF, 1'b0, 1'b0);
      queue_request(8'h00, 1'b0, 1'b0);
      queue_request(8'h61, 1'b1, 1'b0);
      queue_request(8'h62, 1'b1, 1'b0);
      queue_request(8'h63, 1'b1, 1'b1);
      queue_request(8'h00, 1'b1, 1'b0);
      queue_request(8'hAA, 1'b0, 1'b0);
      queue_request(8'hFF, 1'b1, 1'b0);
      queue_request(8'h55, 1'b0, 1'b1);
      queue_request(8'h80, 1'b1, 1'b1);
      queue_request(8'hFF, 1'b0, 1'b1);

      // Random: mostly clean messages at block boundaries, some with noise.
      while (counted_items < RandomItems)
         queue_message(pick_length(), $urandom_range(3) == 0);
      total_requests = pending_requests.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (accepted_count < total_requests || digest_queue.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d requests (%0d data or end) hashed into %0d checked digests,",
               total_requests, counted_items, digests_checked);
      $display("paced with sender gaps, receiver stalls, then back-to-back traffic");
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
